// ----- rtl/core/bsas_pkg.sv -----
// Shared types and codes for the bounded array stack with search.
// Used by bsas_seq and bounded_stack_array_with_search; no dependencies.
package bsas_pkg;

   // fixed field widths of the request and response words
   localparam int CMD_W    = 3;
   localparam int IDX_W    = 4;
   localparam int FIELD_W  = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

   // back and front report this when the stack is empty
   localparam logic [FIELD_W-1:0] EMPTY_WORD = '1;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_WAIT,
      SEQ_SCAN,
      SEQ_DONE
   } bsas_state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  read_value;
      logic                found;
      logic [IDX_W-1:0]    found_index;
      logic [COUNT_W-1:0]  entry_count;
      logic [FIELD_W-1:0]  back_value;
      logic [FIELD_W-1:0]  front_value;
   } bsas_result_type;

endpackage

// ----- rtl/core/bsas_mem.sv -----
// Entry storage: one write port and one read port, read data registered.
// No dependencies.
module bsas_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] entry_mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bsas_seq.sv -----
// Command sequencer: holds the count and the top and bottom entries, drives
// the entry memory and scans it for find. Depends on bsas_pkg.
module bsas_seq #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bsas_pkg::CMD_W-1:0]       req_command,
   input  logic [bsas_pkg::IDX_W-1:0]       req_index,
   input  logic [bsas_pkg::FIELD_W-1:0]     req_value,
   output logic                             mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]         mem_wr_addr,
   output logic [DATA_WIDTH-1:0]            mem_wr_data,
   output logic                             mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]         mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]            mem_rd_data,
   output logic                             res_valid,
   input  logic                             res_free,
   output bsas_pkg::bsas_result_type        res
);
   import bsas_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   bsas_state_type        state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [DATA_WIDTH-1:0] rd_ff, rd_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         scan_ff, scan_in;

   logic          req_fire;
   logic          idx_in_range;
   logic          idx_is_top;
   logic          is_empty;
   logic          needs_wait;
   logic          needs_scan;
   logic          scan_match;
   logic          scan_last;
   logic [AW-1:0] scan_next;
   logic [CW-1:0] count_dec;

   // shared decode of the held word against the current count
   always_comb begin
      req_fire     = req_valid && (state_ff == SEQ_IDLE);
      is_empty     = (count_ff == '0);
      count_dec    = count_ff - CW'(1);
      idx_in_range = XW'(idx_ff) < XW'(count_ff);
      idx_is_top   = XW'(idx_ff) == XW'(count_dec);
      scan_next    = scan_ff + AW'(1);
      scan_match   = (mem_rd_data == val_ff);
      scan_last    = ((CW'(scan_ff) + CW'(1)) == count_ff);
      needs_wait   = ((cmd_ff == CMD_POP) && (count_ff > CW'(1)))
                  || ((cmd_ff == CMD_READ) && idx_in_range);
      needs_scan   = (cmd_ff == CMD_FIND) && !is_empty;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               state_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            if (needs_scan) begin
               state_in = SEQ_SCAN;
            end else if (needs_wait) begin
               state_in = SEQ_WAIT;
            end else begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_WAIT: begin
            state_in = SEQ_DONE;
         end
         SEQ_SCAN: begin
            if (scan_match || scan_last) begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (res_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      count_in    = count_ff;
      back_in     = back_ff;
      front_in    = front_ff;
      status_in   = status_ff;
      rd_in       = rd_ff;
      found_in    = found_ff;
      scan_in     = scan_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[AW-1:0];
      mem_wr_data = val_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = AW'(idx_ff);
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_command;
               idx_in    = req_index;
               val_in    = DATA_WIDTH'($unsigned(req_value));
               status_in = STAT_OK;
               rd_in     = '0;
               found_in  = 1'b0;
               scan_in   = '0;
            end
         end
         SEQ_EXEC: begin
            case (cmd_ff)
               CMD_PUSH: begin
                  if (count_ff == FULL_COUNT) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                     back_in   = val_ff;
                     if (is_empty) begin
                        front_in = val_ff;
                     end
                  end
               end
               CMD_POP: begin
                  if (is_empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     count_in = count_dec;
                     // new top comes back from memory
                     if (count_ff > CW'(1)) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(count_ff - CW'(2));
                     end
                  end
               end
               CMD_READ: begin
                  if (!idx_in_range) begin
                     status_in = STAT_RANGE;
                  end else begin
                     mem_rd_en = 1'b1;
                  end
               end
               CMD_WRITE: begin
                  if (!idx_in_range) begin
                     status_in = STAT_RANGE;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(idx_ff);
                     if (idx_is_top) begin
                        back_in = val_ff;
                     end
                     if (idx_ff == '0) begin
                        front_in = val_ff;
                     end
                  end
               end
               CMD_FIND: begin
                  if (is_empty) begin
                     status_in = STAT_NOT_FOUND;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = '0;
                  end
               end
               default: begin
                  // unused codes leave everything as is
               end
            endcase
         end
         SEQ_WAIT: begin
            if (cmd_ff == CMD_POP) begin
               back_in = mem_rd_data;
            end else begin
               rd_in = mem_rd_data;
            end
         end
         SEQ_SCAN: begin
            // read data belongs to scan_ff; next address goes out meanwhile
            if (scan_match) begin
               found_in = 1'b1;
            end else if (scan_last) begin
               status_in = STAT_NOT_FOUND;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = scan_next;
               scan_in     = scan_next;
            end
         end
         SEQ_DONE: begin
            // hold until the output register takes the word
         end
         default: begin
         end
      endcase
   end

   // handshake and result word
   always_comb begin
      req_ready       = (state_ff == SEQ_IDLE);
      res_valid       = (state_ff == SEQ_DONE);
      res.status      = status_ff;
      res.read_value  = FIELD_W'($signed(rd_ff));
      res.found       = found_ff;
      res.found_index = found_ff ? IDX_W'(scan_ff) : '0;
      res.entry_count = COUNT_W'(count_ff);
      res.back_value  = is_empty ? EMPTY_WORD : FIELD_W'($signed(back_ff));
      res.front_value = is_empty ? EMPTY_WORD : FIELD_W'($signed(front_ff));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      back_ff   <= back_in;
      front_ff  <= front_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
      found_ff  <= found_in;
      scan_ff   <= scan_in;
   end

   // count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above depth");

   // a write and a read never go to the memory in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("memory read and write overlap");

   // count moves only out of the execute step
   a_count_only_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff != SEQ_EXEC) |=> $stable(count_ff))
      else $error("count changed outside execute");

   // count moves by at most one per command
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_EXEC) |=> (count_ff == $past(count_ff))
         || (count_ff == $past(count_ff) + CW'(1))
         || (count_ff == $past(count_ff) - CW'(1)))
      else $error("count jumped");

endmodule

// ----- rtl/core/bounded_stack_array_with_search.sv -----
// Bounded array stack with indexed access and linear search: top level.
// Depends on bsas_pkg, bsas_mem and bsas_seq.
//
//   channel | ports               | handshake     | word
//   --------+---------------------+---------------+---------------------------------
//   request | req_*               | valid / ready | command, index, value
//   result  | rsp_*               | valid / ready | status, read, find, count, ends
//
// One command at a time. Push, overwrite, refused and unused commands pass
// through accept, execute and done; a pop that leaves entries behind and an
// in-range read add a wait state for the registered memory read, a pop of
// the last entry does not, and find adds a scan state that compares entries
// one per cycle through the single memory read port (none on an empty stack).
// Reset clears the count and the sequencer; the entry memory is not cleared.
// The result sits in an output register, so a new command is accepted while
// a finished word waits; a stalled result holds the next one in the sequencer.
module bounded_stack_array_with_search #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bsas_pkg::CMD_W-1:0]            req_command,
   input  logic [bsas_pkg::IDX_W-1:0]            req_index,
   input  logic signed [bsas_pkg::FIELD_W-1:0]   req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bsas_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [bsas_pkg::FIELD_W-1:0]   rsp_read_value,
   output logic                                  rsp_found,
   output logic [bsas_pkg::IDX_W-1:0]            rsp_found_index,
   output logic [bsas_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic signed [bsas_pkg::FIELD_W-1:0]   rsp_back_value,
   output logic signed [bsas_pkg::FIELD_W-1:0]   rsp_front_value
);
   import bsas_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   logic            res_valid;
   logic            res_free;
   bsas_result_type res;

   logic            rsp_valid_ff, rsp_valid_in;
   bsas_result_type rsp_word_ff, rsp_word_in;

   bsas_seq #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_index   (req_index),
      .req_value   (req_value),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_free    (res_free),
      .res         (res)
   );

   bsas_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register: loads when empty or being drained
   always_comb begin
      res_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = (res_valid && res_free) || (rsp_valid_ff && !rsp_ready);
      rsp_word_in  = (res_valid && res_free) ? res : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   // result word onto the ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_word_ff.status;
   assign rsp_read_value  = rsp_word_ff.read_value;
   assign rsp_found       = rsp_word_ff.found;
   assign rsp_found_index = rsp_word_ff.found_index;
   assign rsp_entry_count = rsp_word_ff.entry_count;
   assign rsp_back_value  = rsp_word_ff.back_value;
   assign rsp_front_value = rsp_word_ff.front_value;

endmodule

// ----- bench/bounded_stack_array_with_search_test.sv -----
// Self-checking bench for the bounded array stack with indexed access and search.
// Depends on bsas_pkg and bounded_stack_array_with_search; drives commands, mirrors
// the stack in a local copy and compares every result word field by field.
module bounded_stack_array_with_search_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bsas_pkg::*;

   localparam int STACK_DEPTH  = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 200;
   localparam int SETTLE_TIME  = 40;
   localparam int RANDOM_WORDS = 1600;

   // command codes the block ignores
   localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [IDX_W-1:0]   index;
      logic [FIELD_W-1:0] value;
   } stack_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CMD_W-1:0] req_command = '0;
   logic [IDX_W-1:0] req_index = '0;
   logic signed [FIELD_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic signed [FIELD_W-1:0] rsp_read_value;
   logic rsp_found;
   logic [IDX_W-1:0] rsp_found_index;
   logic [COUNT_W-1:0] rsp_entry_count;
   logic signed [FIELD_W-1:0] rsp_back_value;
   logic signed [FIELD_W-1:0] rsp_front_value;

   // stimulus and scoreboard state
   stack_cmd_type command_queue[$];
   bsas_result_type stack_replies[$];
   logic [FIELD_W-1:0] stack_mem [STACK_DEPTH];
   int stack_depth = 0;
   int peak_depth = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_wanted = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;
   int error_count = 0;
   int cycle_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int input_stall_cycles = 0;
   int finds_matched = 0;
   int status_seen [8];
   logic [FIELD_W-1:0] value_pool [8];

   bounded_stack_array_with_search uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_index       (req_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count),
      .rsp_back_value  (rsp_back_value),
      .rsp_front_value (rsp_front_value)
   );

   // 20 ns clock
   always #10 clock = ~clock;

   // apply one command to the local stack copy and return the word it should give
   function automatic bsas_result_type step_stack(input stack_cmd_type cmd);
      bsas_result_type word;
      bit hit;
      word = '0;
      hit = 1'b0;
      word.status = STAT_OK;
      case (cmd.command)
         CMD_PUSH: begin
            if (stack_depth >= STACK_DEPTH) begin
               word.status = STAT_FULL;
            end else begin
               stack_mem[stack_depth] = cmd.value;
               stack_depth++;
            end
         end
         CMD_POP: begin
            if (stack_depth == 0) word.status = STAT_EMPTY;
            else stack_depth--;
         end
         CMD_READ: begin
            if (int'(cmd.index) >= stack_depth) word.status = STAT_RANGE;
            else word.read_value = stack_mem[cmd.index];
         end
         CMD_WRITE: begin
            if (int'(cmd.index) >= stack_depth) word.status = STAT_RANGE;
            else stack_mem[cmd.index] = cmd.value;
         end
         CMD_FIND: begin
            word.status = STAT_NOT_FOUND;
            // lowest matching index wins
            for (int i = 0; i < stack_depth; i++) begin
               if (!hit && stack_mem[i] == cmd.value) begin
                  hit = 1'b1;
                  word.status = STAT_OK;
                  word.found = 1'b1;
                  word.found_index = i[IDX_W-1:0];
               end
            end
            if (hit) finds_matched++;
         end
         default: ;
      endcase
      word.entry_count = stack_depth[COUNT_W-1:0];
      word.back_value  = (stack_depth > 0) ? stack_mem[stack_depth-1] : EMPTY_WORD;
      word.front_value = (stack_depth > 0) ? stack_mem[0] : EMPTY_WORD;
      if (stack_depth > peak_depth) peak_depth = stack_depth;
      status_seen[word.status]++;
      return word;
   endfunction

   function automatic bit field_ok(input string label, input logic [FIELD_W-1:0] want,
                                   input logic [FIELD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // request driver: next word from the queue, with random gaps
   always @(posedge clock) begin : drive_requests
      stack_cmd_type next_cmd;
      if (reset) begin
         req_valid   <= 1'b0;
         req_command <= '0;
         req_index   <= '0;
         req_value   <= '0;
      end else begin
         if (req_valid && req_ready) begin
            stack_replies = {stack_replies,
                             step_stack({req_command, req_index, req_value})};
            words_sent++;
         end
         if (req_valid && !req_ready) input_stall_cycles++;
         if (!req_valid || req_ready) begin
            if (command_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd = command_queue.pop_front();
               req_valid   <= 1'b1;
               req_command <= next_cmd.command;
               req_index   <= next_cmd.index;
               req_value   <= next_cmd.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare against the oldest predicted word, random stalls
   always @(posedge clock) begin : check_results
      bsas_result_type want;
      bit ok;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (stack_replies.size() == 0) begin
               $display("%0t: unexpected result word, status %0d count %0d", $time,
                        rsp_status, rsp_entry_count);
               error_count++;
            end else begin
               want = stack_replies.pop_front();
               ok = 1'b1;
               ok &= field_ok("status", want.status, rsp_status);
               ok &= field_ok("read_value", want.read_value, rsp_read_value);
               ok &= field_ok("found", want.found, rsp_found);
               ok &= field_ok("found_index", want.found_index, rsp_found_index);
               ok &= field_ok("entry_count", want.entry_count, rsp_entry_count);
               ok &= field_ok("back_value", want.back_value, rsp_back_value);
               ok &= field_ok("front_value", want.front_value, rsp_front_value);
               if (!ok) error_count++;
               words_checked++;
            end
         end
         // long back-pressure stretch, counted here
         if (hold_wanted && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count,
                  stack_replies.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic queue_cmd(input logic [CMD_W-1:0] command, input int index,
                            input logic [FIELD_W-1:0] value);
      stack_cmd_type c;
      c.command = command;
      c.index   = index[IDX_W-1:0];
      c.value   = value;
      command_queue = {command_queue, c};
   endtask

   // wait until every queued word went in and every result came back
   task automatic wait_for_drain();
      do @(negedge clock);
      while (command_queue.size() > 0 || req_valid || stack_replies.size() > 0);
   endtask

   // random words, biased to fill, drain or mix the stack in turns
   task automatic queue_random_commands(input int n);
      int made;
      int mode;
      int roll;
      logic [CMD_W-1:0] command;
      logic [FIELD_W-1:0] value;
      int index;
      made = 0;
      while (made < n) begin
         mode = (made / 40) % 3;
         roll = $urandom_range(99);
         case (mode)
            0: command = (roll < 45) ? CMD_PUSH : (roll < 55) ? CMD_POP :
                         (roll < 70) ? CMD_READ : (roll < 80) ? CMD_WRITE :
                         (roll < 97) ? CMD_FIND : CMD_SPARE_5;
            1: command = (roll < 10) ? CMD_PUSH : (roll < 50) ? CMD_POP :
                         (roll < 65) ? CMD_READ : (roll < 77) ? CMD_WRITE :
                         (roll < 97) ? CMD_FIND : CMD_SPARE_6;
            default: command = (roll < 25) ? CMD_PUSH : (roll < 47) ? CMD_POP :
                               (roll < 65) ? CMD_READ : (roll < 80) ? CMD_WRITE :
                               (roll < 97) ? CMD_FIND : CMD_SPARE_7;
         endcase
         // pool values make finds hit and duplicates appear
         if ($urandom_range(1)) value = value_pool[$urandom_range(7)];
         else value = $urandom;
         index = $urandom_range(1) ? $urandom_range(15) : $urandom_range(5);
         queue_cmd(command, index, value);
         if (command != CMD_SPARE_5 && command != CMD_SPARE_6 && command != CMD_SPARE_7)
            made++;
      end
   endtask

   // stimulus sequence
   initial begin
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      value_pool[0] = '0;
      value_pool[1] = '1;
      value_pool[2] = 32'h8000_0000;
      value_pool[3] = 32'h7fff_ffff;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      send_idle_pct = 14;
      recv_idle_pct = 88;

      // refusals on an empty stack and ignored codes
      queue_cmd(CMD_POP, 0, '0);
      queue_cmd(CMD_READ, 0, '0);
      queue_cmd(CMD_WRITE, 15, 32'h7fff_ffff);
      queue_cmd(CMD_FIND, 0, '0);
      queue_cmd(CMD_SPARE_5, 15, '1);
      queue_cmd(CMD_SPARE_6, 7, 32'h8000_0000);
      queue_cmd(CMD_SPARE_7, 0, 32'h7fff_ffff);
      // extremes, duplicate so find must pick the lowest index
      queue_cmd(CMD_PUSH, 0, 32'h8000_0000);
      queue_cmd(CMD_PUSH, 0, 32'h7fff_ffff);
      queue_cmd(CMD_READ, 1, '0);
      queue_cmd(CMD_WRITE, 0, 32'h7fff_ffff);
      queue_cmd(CMD_FIND, 0, 32'h7fff_ffff);
      // fill to the top, then push into a full stack
      for (int i = 0; i < STACK_DEPTH - 2; i++)
         queue_cmd(CMD_PUSH, i, (i == 0) ? '1 : (i == 1) ? '0 : $urandom);
      queue_cmd(CMD_PUSH, 15, 32'h1234_5678);
      queue_cmd(CMD_READ, 15, '0);
      wait_for_drain();

      // sender mostly busy, receiver mostly stalled
      queue_random_commands(RANDOM_WORDS / 3);
      wait_for_drain();

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 88;
      recv_idle_pct = 14;
      queue_random_commands(RANDOM_WORDS / 3);
      wait_for_drain();

      // no idling, with one long receiver hold-off at the start
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_commands(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
      hold_wanted = 1'b1;
      wait_for_drain();

      repeat (SETTLE_TIME) @(negedge clock);
      if (stack_replies.size() > 0) begin
         $display("%0d result words never arrived", stack_replies.size());
         error_count++;
      end

      $display("ran %0d words: %0d full, %0d empty, %0d out-of-range, %0d not-found refusals",
               words_sent, status_seen[STAT_FULL], status_seen[STAT_EMPTY],
               status_seen[STAT_RANGE], status_seen[STAT_NOT_FOUND]);
      $display("finds matched %0d, peak depth %0d, input stalled %0d cycles, %0d errors",
               finds_matched, peak_depth, input_stall_cycles, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/bsas_pkg.sv
rtl/core/bsas_mem.sv
rtl/core/bsas_seq.sv
rtl/core/bounded_stack_array_with_search.sv
bench/bounded_stack_array_with_search_test.sv
